// ===== sv/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES   = 32768;
  localparam int HEADER_BYTES = 24;
  localparam int SPLIT_SLACK  = 32;
  localparam int ALIGN_MASK   = 7;
  localparam int OFF_W        = $clog2(HEAP_BYTES) + 1;
  localparam int IDX_W        = $clog2(HEAP_BYTES) - 3;
  localparam int DEPTH        = HEAP_BYTES / 8;
  localparam int SIZE_W       = OFF_W;
  localparam int ADDR_W       = 48;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [15:0]       req_size;
    logic [ADDR_W-1:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_addr;
    logic              ok;
  } out_item_t;

  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    hdr_t             wr_data;
  } ram_req_t;

endpackage

// ===== sv/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator: top level with the block-walk sequencer.
//
// The heap is kept as headers in a memory indexed by block offset / 8. An
// allocate walks the block chain from offset 0, with one header read and one
// evaluation per block, then writes the header and, on a split, the header of
// the free tail. A free walks the chain the same way to find the block, writes
// it free, then runs a merge pass over the whole chain. A null free skips the
// walk and answers directly. One item is in work at a time; the result sits in
// an output register, so the next item can be taken while it waits. No
// clearing pass: only the first header has a reset value, held by a flag until
// it is first written.
module first_fit_heap_allocator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffha_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [47:0]         cfg_data
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ARD    = 4'd1;
  localparam logic [3:0] S_AEVAL  = 4'd2;
  localparam logic [3:0] S_ASPLIT = 4'd3;
  localparam logic [3:0] S_FRD    = 4'd4;
  localparam logic [3:0] S_FEVAL  = 4'd5;
  localparam logic [3:0] S_M0     = 4'd6;
  localparam logic [3:0] S_M1     = 4'd7;
  localparam logic [3:0] S_MCHK   = 4'd8;
  localparam logic [3:0] S_M3     = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam logic [OFF_W-1:0]  HEAP_END = OFF_W'(HEAP_BYTES);
  localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W:0]   ALIGN_M  = (SIZE_W+1)'(ALIGN_MASK);
  localparam logic [SIZE_W+1:0] SPLIT_MIN = (SIZE_W+2)'(HEADER_BYTES + SPLIT_SLACK);

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              h0_valid_r, h0_valid_nxt;
  logic              ovr_r, ovr_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  nxt_off_r, nxt_off_nxt;
  hdr_t              cur_r, cur_nxt;
  logic [SIZE_W:0]   need_r, need_nxt;
  logic [SIZE_W-1:0] tail_r, tail_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  ram_req_t          ram_req;
  hdr_t              ram_rd;
  hdr_t              rd_hdr;
  logic [ADDR_W-1:0] pay_addr;
  logic [OFF_W-1:0]  walk_nxt;
  logic [SIZE_W-1:0] merged_size;

  ffha_hdr_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  // first header reads as one free block over the whole heap until written
  assign rd_hdr = ovr_r ? hdr_t'{is_free: 1'b1, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)}
                        : ram_rd;

  assign pay_addr    = base_r + {{(ADDR_W-OFF_W){1'b0}}, off_r} + ADDR_W'(HEADER_BYTES);
  assign walk_nxt    = off_r + HDR_OFF + rd_hdr.size;
  assign merged_size = cur_r.size + HDR_OFF + rd_hdr.size;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    h0_valid_nxt  = h0_valid_r;
    off_nxt       = off_r;
    nxt_off_nxt   = nxt_off_r;
    cur_nxt       = cur_r;
    need_nxt      = need_r;
    tail_nxt      = tail_r;
    faddr_nxt     = faddr_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_req       = '0;

    if (cfg_valid && cfg_ready) begin
      base_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          off_nxt      = '0;
          faddr_nxt    = in_data.free_addr;
          need_nxt     = ({1'b0, in_data.req_size} + ALIGN_M) & ~ALIGN_M;
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          if (in_data.op == OP_ALLOC) begin
            state_nxt = S_ARD;
          end else if (in_data.free_addr == '0) begin
            res_ok_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        if (off_r == HEAP_END) begin
          state_nxt = S_DONE;
        end else begin
          ram_req.rd_en  = 1'b1;
          ram_req.rd_idx = off_r[IDX_W+2:3];
          state_nxt      = S_AEVAL;
        end
      end
      S_AEVAL: begin
        if (rd_hdr.is_free && ({1'b0, rd_hdr.size} >= need_r)) begin
          ram_req.wr_en          = 1'b1;
          ram_req.wr_idx         = off_r[IDX_W+2:3];
          ram_req.wr_data.is_free = 1'b0;
          res_addr_nxt           = pay_addr;
          res_ok_nxt             = 1'b1;
          if (off_r == '0) h0_valid_nxt = 1'b1;
          if ({1'b0, rd_hdr.size} >= ({1'b0, need_r} + SPLIT_MIN)) begin
            ram_req.wr_data.size = need_r[SIZE_W-1:0];
            tail_nxt    = rd_hdr.size - need_r[SIZE_W-1:0] - HDR_OFF;
            nxt_off_nxt = off_r + HDR_OFF + need_r[SIZE_W-1:0];
            state_nxt   = S_ASPLIT;
          end else begin
            ram_req.wr_data.size = rd_hdr.size;
            state_nxt = S_DONE;
          end
        end else begin
          off_nxt   = walk_nxt;
          state_nxt = S_ARD;
        end
      end
      S_ASPLIT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_idx  = nxt_off_r[IDX_W+2:3];
        ram_req.wr_data = hdr_t'{is_free: 1'b1, size: tail_r};
        state_nxt       = S_DONE;
      end
      S_FRD: begin
        if (off_r == HEAP_END) begin
          state_nxt = S_DONE;
        end else begin
          ram_req.rd_en  = 1'b1;
          ram_req.rd_idx = off_r[IDX_W+2:3];
          state_nxt      = S_FEVAL;
        end
      end
      S_FEVAL: begin
        if (pay_addr == faddr_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_idx  = off_r[IDX_W+2:3];
          ram_req.wr_data = hdr_t'{is_free: 1'b1, size: rd_hdr.size};
          if (off_r == '0) h0_valid_nxt = 1'b1;
          res_ok_nxt = 1'b1;
          state_nxt  = S_M0;
        end else begin
          off_nxt   = walk_nxt;
          state_nxt = S_FRD;
        end
      end
      // merge pass over the whole chain
      S_M0: begin
        ram_req.rd_en  = 1'b1;
        ram_req.rd_idx = '0;
        off_nxt        = '0;
        state_nxt      = S_M1;
      end
      S_M1: begin
        cur_nxt   = rd_hdr;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if ((off_r + HDR_OFF + cur_r.size) == HEAP_END) begin
          state_nxt = S_DONE;
        end else begin
          nxt_off_nxt    = off_r + HDR_OFF + cur_r.size;
          ram_req.rd_en  = 1'b1;
          ram_req.rd_idx = nxt_off_nxt[IDX_W+2:3];
          state_nxt      = S_M3;
        end
      end
      S_M3: begin
        if (cur_r.is_free && rd_hdr.is_free) begin
          cur_nxt.size    = merged_size;
          ram_req.wr_en   = 1'b1;
          ram_req.wr_idx  = off_r[IDX_W+2:3];
          ram_req.wr_data = hdr_t'{is_free: 1'b1, size: merged_size};
          if (off_r == '0) h0_valid_nxt = 1'b1;
        end else begin
          off_nxt = nxt_off_r;
          cur_nxt = rd_hdr;
        end
        state_nxt = S_MCHK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_item_t'{payload_addr: res_addr_r, ok: res_ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ovr_nxt = ram_req.rd_en && (ram_req.rd_idx == '0) && !h0_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      h0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ovr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      h0_valid_r  <= h0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_req.rd_en) ovr_r <= ovr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    nxt_off_r  <= nxt_off_nxt;
    cur_r      <= cur_nxt;
    need_r     <= need_nxt;
    tail_r     <= tail_nxt;
    faddr_r    <= faddr_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/ffha_hdr_ram.sv =====
// Header memory: one header per 8-byte heap slot, registered read.
module ffha_hdr_ram (
  input  logic              clk,
  input  ffha_pkg::ram_req_t req,
  output ffha_pkg::hdr_t    rd_data
);
  import ffha_pkg::*;

  hdr_t mem [DEPTH];
  hdr_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ffha_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module ffha_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ffha_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ffha_pkg::out_item_t out_data
);

  // a waiting result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a nonzero address only comes with success
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.payload_addr != '0) |-> out_data.ok)
    else $error("address given on failure");

  // a null free answers ok with a null address
  a_null_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op && (in_data.free_addr == '0) && !out_valid
    |=> ##1 out_valid && out_data.ok && (out_data.payload_addr == '0))
    else $error("null free not answered");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/first_fit_heap_allocator_unit_test.sv =====
// Self-checking testbench for the first-fit heap allocator unit.
module first_fit_heap_allocator_unit_test;
  import ffha_pkg::*;

  localparam int MAX_BLK   = HEAP_BYTES / HEADER_BYTES + 1;
  localparam int LIMIT_CYC = 20000000;
  localparam int DRAIN_CYC = 4 * MAX_BLK + 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [47:0] cfg_data = '0;

  first_fit_heap_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow heap: block list plus base register
  int unsigned  blk_len [MAX_BLK];
  bit           blk_avail [MAX_BLK];
  int unsigned  blk_num;
  logic [47:0]  base_addr;

  out_item_t    pending_q[$];
  logic [47:0]  live_q[$];
  int           errors = 0;
  int           n_items = 0;
  int           n_results = 0;
  int           n_alloc_ok = 0;
  int           n_alloc_fail = 0;
  int           n_frees = 0;
  longint       cycles = 0;
  bit           sending_done = 1'b0;
  int           hold_off = 0;

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  function automatic logic [47:0] addr_at(input longint unsigned off);
    return base_addr + 48'(off) + 48'(HEADER_BYTES);
  endfunction

  // Fold adjacent free blocks together
  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_num) begin
      if (blk_avail[i] && blk_avail[i+1]) begin
        blk_len[i] += HEADER_BYTES + blk_len[i+1];
        for (int unsigned j = i + 1; j + 1 < blk_num; j++) begin
          blk_len[j] = blk_len[j+1];
          blk_avail[j] = blk_avail[j+1];
        end
        blk_num--;
      end else begin
        i++;
      end
    end
  endfunction

  // Expected result of one item; updates the shadow heap
  function automatic out_item_t heap_step(input in_item_t it);
    out_item_t r;
    longint unsigned off, need;
    r = '0;
    off = 0;
    if (it.op == OP_ALLOC) begin
      need = (longint'(it.req_size) + ALIGN_MASK) & ~longint'(ALIGN_MASK);
      for (int unsigned i = 0; i < blk_num; i++) begin
        if (blk_avail[i] && blk_len[i] >= need) begin
          if (blk_len[i] >= need + HEADER_BYTES + SPLIT_SLACK && blk_num < MAX_BLK) begin
            for (int unsigned j = blk_num; j > i + 1; j--) begin
              blk_len[j] = blk_len[j-1];
              blk_avail[j] = blk_avail[j-1];
            end
            blk_len[i+1] = 32'(blk_len[i] - need - HEADER_BYTES);
            blk_avail[i+1] = 1'b1;
            blk_len[i] = 32'(need);
            blk_num++;
          end
          blk_avail[i] = 1'b0;
          r.payload_addr = addr_at(off);
          r.ok = 1'b1;
          return r;
        end
        off += HEADER_BYTES + blk_len[i];
      end
    end else begin
      if (it.free_addr == '0) begin
        r.ok = 1'b1;
        return r;
      end
      for (int unsigned i = 0; i < blk_num; i++) begin
        if (addr_at(off) == it.free_addr) begin
          blk_avail[i] = 1'b1;
          coalesce();
          r.ok = 1'b1;
          return r;
        end
        off += HEADER_BYTES + blk_len[i];
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
  endfunction

  // Send one item and queue its expected result; chk_* are typed-in values
  task automatic send(input in_item_t it, input bit chk, input logic [47:0] chk_addr,
                      input logic chk_ok);
    out_item_t e;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = heap_step(it);
    if (chk && (e.payload_addr !== chk_addr || e.ok !== chk_ok))
      report("directed table", e.payload_addr, chk_addr);
    pending_q.push_back(e);
    if (it.op == OP_ALLOC && e.ok) live_q.push_back(e.payload_addr);
    if (it.op == OP_ALLOC) begin
      if (e.ok) n_alloc_ok++; else n_alloc_fail++;
    end else n_frees++;
    n_items++;
    repeat (gap_len()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic idle_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_base(input logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_addr = v;
    live_q.delete();
  endtask

  function automatic in_item_t mk(input logic op, input int sz, input logic [47:0] a);
    in_item_t it;
    it.op = op;
    it.req_size = 16'(sz);
    it.free_addr = a;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int k;
    int unsigned sz;
    k = $urandom_range(0, 99);
    if (k < 50) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
      return mk(OP_ALLOC, sz, 48'({$urandom, $urandom}));
    end
    if (k < 88 && live_q.size() != 0) begin
      int idx;
      logic [47:0] a;
      idx = $urandom_range(0, live_q.size() - 1);
      a = live_q[idx];
      live_q.delete(idx);
      return mk(OP_FREE, $urandom_range(0, 65535), a);
    end
    if (k < 94) return mk(OP_FREE, 0, 48'(base_addr + 48'($urandom_range(0, 2000))));
    if (k < 97) return mk(OP_FREE, 0, 48'({$urandom, $urandom}));
    return mk(OP_FREE, $urandom_range(0, 65535), '0);
  endfunction

  // Result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
    end
    if (rst_n && out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (pending_q.size() == 0) begin
        report("unexpected result", out_data.payload_addr, '0);
      end else begin
        out_item_t e;
        e = pending_q.pop_front();
        if (out_data.payload_addr !== e.payload_addr)
          report("payload_addr", out_data.payload_addr, e.payload_addr);
        if (out_data.ok !== e.ok)
          report("ok", 48'(out_data.ok), 48'(e.ok));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    in_item_t    it;
    bit          chk;
    logic [47:0] addr;
    logic        ok;
  } row_t;

  row_t dir_rows[$];

  initial begin
    blk_num = 1;
    blk_len[0] = HEAP_BYTES - HEADER_BYTES;
    blk_avail[0] = 1'b1;
    base_addr = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, null and unknown frees, oversize
    dir_rows = '{
      '{mk(OP_ALLOC, 0, '0), 1, 48'd24, 1'b1},
      '{mk(OP_ALLOC, 1, '0), 1, 48'd48, 1'b1},
      '{mk(OP_ALLOC, 65535, '1), 1, '0, 1'b0},
      '{mk(OP_ALLOC, 32768, '0), 1, '0, 1'b0},
      '{mk(OP_FREE, 0, '0), 1, '0, 1'b1},
      '{mk(OP_FREE, 65535, '1), 1, '0, 1'b0},
      '{mk(OP_FREE, 0, 48'd25), 1, '0, 1'b0},
      '{mk(OP_FREE, 0, 48'd24), 1, '0, 1'b1},
      '{mk(OP_FREE, 0, 48'd24), 1, '0, 1'b1},
      '{mk(OP_ALLOC, 40, '0), 0, '0, 1'b0},
      '{mk(OP_FREE, 0, 48'd48), 0, '0, 1'b0},
      '{mk(OP_ALLOC, 32744, '0), 0, '0, 1'b0},
      '{mk(OP_ALLOC, 8, '0), 1, 48'd24, 1'b1},
      '{mk(OP_FREE, 0, 48'd24), 1, '0, 1'b1},
      '{mk(OP_FREE, 0, 48'd24), 0, '0, 1'b0},
      '{mk(OP_ALLOC, 32700, '0), 0, '0, 1'b0},
      '{mk(OP_ALLOC, 16, '0), 0, '0, 1'b0}
    };
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].addr, dir_rows[i].ok);
    idle_out();

    // Top of the address range: addresses wrap modulo 2^48
    write_base(48'hFFFF_FFFF_FFF0);
    send(mk(OP_FREE, 0, 48'd8), 0, '0, 1'b0);
    send(mk(OP_FREE, 0, 48'd8 + 48'(HEADER_BYTES + 8)), 0, '0, 1'b0);
    send(mk(OP_ALLOC, 100, '1), 0, '0, 1'b0);
    idle_out();

    // Random phases under several base settings
    for (int ph = 0; ph < 4; ph++) begin
      write_base(ph == 0 ? 48'h0 : ph == 3 ? 48'hFFFF_FFFF_FF00 : 48'({$urandom, $urandom}));
      for (int n = 0; n < 340; n++) begin
        if (ph == 1 && n == 100) begin
          // Stall the result side long; keep sending so the input backs up
          hold_off = 400;
        end
        if (ph == 2 && n == 150) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
        send(rand_item(), 0, '0, 1'b0);
      end
      idle_out();
    end

    $display("covered %0d items: %0d allocations granted, %0d refused, %0d frees",
             n_items, n_alloc_ok, n_alloc_fail, n_frees);
    $display("five base settings, null/unknown/double frees, long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
